>>> sv/sccb_register_master_defines.svh
// Assertion macros used by the checker file.
`ifndef SCCB_REGISTER_MASTER_DEFINES_SVH
`define SCCB_REGISTER_MASTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCCB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sccb check failed");

// Next-cycle implication, disabled during reset.
`define SCCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sccb check failed");

`endif

>>> sv/sccb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sccb_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUS_BUSY  = 2'd1;
  localparam logic [1:0] ST_ADDR_NACK = 2'd2;

  localparam logic [7:0] DEV_ADDR_RESET = 8'h42;

  typedef enum logic [19:0] {
    PH_IDLE = 20'h00001,
    PH_ST0  = 20'h00002,
    PH_ST1  = 20'h00004,
    PH_ST2  = 20'h00008,
    PH_TXL  = 20'h00010,
    PH_TXD  = 20'h00020,
    PH_TXH  = 20'h00040,
    PH_AK0  = 20'h00080,
    PH_AK1  = 20'h00100,
    PH_AK2  = 20'h00200,
    PH_RXL  = 20'h00400,
    PH_RXH  = 20'h00800,
    PH_MA0  = 20'h01000,
    PH_MA1  = 20'h02000,
    PH_MA2  = 20'h04000,
    PH_MA3  = 20'h08000,
    PH_SP0  = 20'h10000,
    PH_SP1  = 20'h20000,
    PH_SP2  = 20'h40000,
    PH_SP3  = 20'h80000
  } phase_t;

  // Which byte is on the wire.
  typedef enum logic [1:0] {
    BY_DEV1 = 2'd0,
    BY_REG  = 2'd1,
    BY_DATA = 2'd2,
    BY_DEV2 = 2'd3
  } byte_stage_t;

  // What follows a stop.
  typedef enum logic [1:0] {
    STOP_FINAL   = 2'd0,
    STOP_RESTART = 2'd1,
    STOP_ABORT   = 2'd2
  } stop_kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/sccb_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface sccb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] reg_address;
  logic [7:0] write_data;
  logic [7:0] read_length;
  logic       sda_in;
  modport source (output valid, opcode, reg_address, write_data, read_length, sda_in,
                  input ready);
  modport sink (input valid, opcode, reg_address, write_data, read_length, sda_in,
                output ready);
endinterface

interface sccb_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] read_data;
  logic       read_valid;
  logic       read_last;
  modport source (output valid, scl_out, sda_out, busy_res, done_res, status, read_data,
                  read_valid, read_last, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, status, read_data,
                read_valid, read_last, output ready);
endinterface

interface sccb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] device_address;
  modport source (output valid, device_address, input ready);
  modport sink (input valid, device_address, output ready);
endinterface

`default_nettype wire

>>> sv/sccb_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Bus sequencer: one tick of the SCCB state machine per step.
module sccb_engine import sccb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  input  wire logic [7:0] dev_addr,
  output out_item_t      res
);

  phase_t      phase, phase_next, phase_sel;
  logic [2:0]  bit_count, bit_count_next, bit_inc;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next, bytes_dec;
  logic        is_read, is_read_next;
  logic [7:0]  held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;
  logic        second_start, second_start_next;
  logic        clock_drive, clock_drive_next;
  logic        data_drive, data_drive_next;
  byte_stage_t byte_stage, byte_stage_next;
  stop_kind_t  stop_kind, stop_kind_next;
  logic        start;
  logic [7:0]  rx_byte;

  assign start     = (phase == PH_IDLE) && ((item.opcode == OP_WRITE) ||
                                            (item.opcode == OP_READ));
  assign phase_sel = start ? PH_ST0 : phase;
  assign bit_inc   = bit_count + 3'd1;
  assign bytes_dec = bytes_left - 8'd1;
  assign rx_byte   = {shift_byte[6:0], item.sda_in};

  always_comb begin
    phase_next        = phase_sel;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    bytes_left_next   = start ? item.read_length : bytes_left;
    is_read_next      = start ? (item.opcode == OP_READ) : is_read;
    held_address_next = start ? item.reg_address : held_address;
    held_data_next    = start ? item.write_data : held_data;
    second_start_next = start ? 1'b0 : second_start;
    clock_drive_next  = clock_drive;
    data_drive_next   = data_drive;
    byte_stage_next   = byte_stage;
    stop_kind_next    = stop_kind;
    res               = '0;

    unique case (phase_sel)
      PH_IDLE: ;
      PH_ST0: begin
        clock_drive_next = 1'b1;
        data_drive_next  = 1'b1;
        if (!item.sda_in) begin
          res.done_res = 1'b1;
          res.status   = ST_BUS_BUSY;
          phase_next   = PH_IDLE;
        end else begin
          phase_next = PH_ST1;
        end
      end
      PH_ST1: begin
        data_drive_next = 1'b0;
        if (item.sda_in) begin
          res.done_res = 1'b1;
          res.status   = ST_BUS_BUSY;
          phase_next   = PH_IDLE;
        end else begin
          phase_next = PH_ST2;
        end
      end
      PH_ST2: begin
        clock_drive_next = 1'b0;
        bit_count_next   = 3'd0;
        phase_next       = PH_TXL;
        if (second_start) begin
          shift_byte_next = dev_addr + 8'd1;
          byte_stage_next = BY_DEV2;
        end else begin
          shift_byte_next = dev_addr;
          byte_stage_next = BY_DEV1;
        end
      end
      PH_TXL: begin
        clock_drive_next = 1'b0;
        phase_next       = PH_TXD;
      end
      PH_TXD: begin
        data_drive_next = shift_byte[7];
        shift_byte_next = {shift_byte[6:0], 1'b0};
        phase_next      = PH_TXH;
      end
      PH_TXH: begin
        clock_drive_next = 1'b1;
        bit_count_next   = bit_inc;
        phase_next       = (bit_inc == 3'd0) ? PH_AK0 : PH_TXL;
      end
      PH_AK0: begin
        clock_drive_next = 1'b0;
        phase_next       = PH_AK1;
      end
      PH_AK1: begin
        data_drive_next = 1'b1;
        phase_next      = PH_AK2;
      end
      PH_AK2: begin
        clock_drive_next = 1'b1;
        priority if (((byte_stage == BY_DEV1) || (byte_stage == BY_DEV2)) && item.sda_in) begin
          stop_kind_next = STOP_ABORT;
          phase_next     = PH_SP0;
        end else if (byte_stage == BY_DEV1) begin
          shift_byte_next = held_address;
          byte_stage_next = BY_REG;
          bit_count_next  = 3'd0;
          phase_next      = PH_TXL;
        end else if (byte_stage == BY_REG) begin
          if (is_read) begin
            stop_kind_next = STOP_RESTART;
            phase_next     = PH_SP0;
          end else begin
            shift_byte_next = held_data;
            byte_stage_next = BY_DATA;
            bit_count_next  = 3'd0;
            phase_next      = PH_TXL;
          end
        end else if ((byte_stage == BY_DATA) || (bytes_left == 8'd0)) begin
          stop_kind_next = STOP_FINAL;
          phase_next     = PH_SP0;
        end else begin
          bit_count_next  = 3'd0;
          shift_byte_next = 8'd0;
          phase_next      = PH_RXL;
        end
      end
      PH_RXL: begin
        clock_drive_next = 1'b0;
        data_drive_next  = 1'b1;
        phase_next       = PH_RXH;
      end
      PH_RXH: begin
        clock_drive_next = 1'b1;
        shift_byte_next  = rx_byte;
        bit_count_next   = bit_inc;
        if (bit_inc == 3'd0) begin
          res.read_valid = 1'b1;
          res.read_data  = rx_byte;
          res.read_last  = (bytes_left == 8'd1);
          phase_next     = PH_MA0;
        end else begin
          phase_next = PH_RXL;
        end
      end
      PH_MA0: begin
        clock_drive_next = 1'b0;
        phase_next       = PH_MA1;
      end
      PH_MA1: begin
        data_drive_next = (bytes_left == 8'd1);
        phase_next      = PH_MA2;
      end
      PH_MA2: begin
        clock_drive_next = 1'b1;
        phase_next       = PH_MA3;
      end
      PH_MA3: begin
        clock_drive_next = 1'b0;
        bytes_left_next  = bytes_dec;
        if (bytes_dec == 8'd0) begin
          stop_kind_next = STOP_FINAL;
          phase_next     = PH_SP0;
        end else begin
          bit_count_next  = 3'd0;
          shift_byte_next = 8'd0;
          phase_next      = PH_RXL;
        end
      end
      PH_SP0: begin
        clock_drive_next = 1'b0;
        phase_next       = PH_SP1;
      end
      PH_SP1: begin
        data_drive_next = 1'b0;
        phase_next      = PH_SP2;
      end
      PH_SP2: begin
        clock_drive_next = 1'b1;
        phase_next       = PH_SP3;
      end
      PH_SP3: begin
        data_drive_next = 1'b1;
        if (stop_kind == STOP_RESTART) begin
          second_start_next = 1'b1;
          phase_next        = PH_ST0;
        end else begin
          res.done_res = 1'b1;
          res.status   = (stop_kind == STOP_ABORT) ? ST_ADDR_NACK : ST_OK;
          phase_next   = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    res.scl_out  = clock_drive_next;
    res.sda_out  = data_drive_next;
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= 3'd0;
      shift_byte   <= 8'd0;
      bytes_left   <= 8'd0;
      is_read      <= 1'b0;
      held_address <= 8'd0;
      held_data    <= 8'd0;
      second_start <= 1'b0;
      clock_drive  <= 1'b1;
      data_drive   <= 1'b1;
      byte_stage   <= BY_DEV1;
      stop_kind    <= STOP_FINAL;
    end else if (step) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      bytes_left   <= bytes_left_next;
      is_read      <= is_read_next;
      held_address <= held_address_next;
      held_data    <= held_data_next;
      second_start <= second_start_next;
      clock_drive  <= clock_drive_next;
      data_drive   <= data_drive_next;
      byte_stage   <= byte_stage_next;
      stop_kind    <= stop_kind_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/sccb_register_master.sv
`timescale 1ns / 1ps
`default_nettype none

// SCCB register master, driven one bus tick per transaction on req. Each tick
// carries an opcode: tick only, begin a register write, or begin a register
// read; a begin while busy is an ordinary tick. For every tick exactly one
// result comes out on rsp with the clock/data drives (1 = released), busy,
// done with status (0 ok, 1 bus not free at start, 2 device address not
// acknowledged) and, during reads, each received byte with a last flag. The
// device write address is set over cfg (reset 0x42) and must only change
// while idle. Throughput is one tick per clock while rsp is not stalled: the
// sequencer next state is computed combinationally from its registered state,
// with a request register in front and a result register behind, and each
// tick's result passes through both registers on its way to rsp.
module sccb_register_master import sccb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  sccb_in_if.sink   req,
  sccb_out_if.source rsp,
  sccb_cfg_if.sink  cfg
);

  logic       dev_addr;
  logic [7:0] device_address;

  // Request stage.
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_fire;

  // Result stage.
  logic      out_valid;
  out_item_t out_item;
  out_item_t step_res;

  assign dev_addr  = 1'b0;
  assign cfg.ready = 1'b1;

  // Request register advances whenever the result register is free or drained.
  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
    end else if (cfg.valid) begin
      device_address <= cfg.device_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.opcode      <= req.opcode;
      s1_item.reg_address <= req.reg_address;
      s1_item.write_data  <= req.write_data;
      s1_item.read_length <= req.read_length;
      s1_item.sda_in      <= req.sda_in;
    end
  end

  sccb_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_fire),
    .item     (s1_item),
    .dev_addr (device_address ^ {7'd0, dev_addr}),
    .res      (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item <= step_res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.scl_out    = out_item.scl_out;
  assign rsp.sda_out    = out_item.sda_out;
  assign rsp.busy_res   = out_item.busy_res;
  assign rsp.done_res   = out_item.done_res;
  assign rsp.status     = out_item.status;
  assign rsp.read_data  = out_item.read_data;
  assign rsp.read_valid = out_item.read_valid;
  assign rsp.read_last  = out_item.read_last;

endmodule

`default_nettype wire

>>> sv/sccb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sccb_register_master_defines.svh"

module sccb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [1:0] status,
  input wire logic [7:0] read_data,
  input wire logic       read_valid,
  input wire logic       read_last
);

  // A stalled result holds.
  `SCCB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(read_data) && $stable(done_res))

  // A finished transaction leaves the master idle.
  `SCCB_ASSERT_NOW(a_done_idle, clk, rst, rsp_valid && done_res, !busy_res)

  // Status only reports alongside done.
  `SCCB_ASSERT_NOW(a_status_quiet, clk, rst, rsp_valid && !done_res, status == 2'd0)

  // No byte: data and last flag stay clear.
  `SCCB_ASSERT_NOW(a_rx_quiet, clk, rst, rsp_valid && !read_valid, (read_data == 8'd0) && !read_last)

endmodule

bind sccb_register_master sccb_checker u_sccb_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .busy_res   (rsp.busy_res),
  .done_res   (rsp.done_res),
  .status     (rsp.status),
  .read_data  (rsp.read_data),
  .read_valid (rsp.read_valid),
  .read_last  (rsp.read_last)
);

`default_nettype wire

>>> tb/sccb_register_master_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and config channels of sccb_register_master.
// Every accepted tick is run through a local copy of the bus sequencer; the
// predicted result is queued and compared with the next result taken off rsp.
module sccb_register_master_checker import sccb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sccb_in_if         req,
  sccb_out_if        rsp,
  sccb_cfg_if        cfg,
  output int         fail_count,
  output int         pending,
  output int         ticks_checked,
  output int         bytes_read,
  output int         ends_ok,
  output int         ends_bus_busy,
  output int         ends_nack
);

  localparam int MAX_PRINTED = 40;

  out_item_t   tick_results_q[$];

  // Sequencer copy.
  logic [7:0]  dev_addr;
  phase_t      ph;
  logic [2:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [7:0]  left;
  logic        rd;
  logic [7:0]  addr_reg;
  logic [7:0]  data_reg;
  logic        restart_pending;
  logic        scl_d;
  logic        sda_d;
  byte_stage_t stage;
  stop_kind_t  stopk;

  function automatic void reset_sequencer();
    dev_addr = DEV_ADDR_RESET;
    ph = PH_IDLE;
    bit_cnt = '0;
    shreg = '0;
    left = '0;
    rd = 1'b0;
    addr_reg = '0;
    data_reg = '0;
    restart_pending = 1'b0;
    scl_d = 1'b1;
    sda_d = 1'b1;
    stage = BY_DEV1;
    stopk = STOP_FINAL;
  endfunction

  function automatic void load_byte(input logic [7:0] value, input byte_stage_t s);
    shreg = value;
    stage = s;
    bit_cnt = '0;
    ph = PH_TXL;
  endfunction

  function automatic out_item_t bus_tick(input in_item_t t);
    out_item_t o;
    o = '0;
    if (ph == PH_IDLE && (t.opcode == OP_WRITE || t.opcode == OP_READ)) begin
      rd = (t.opcode == OP_READ);
      addr_reg = t.reg_address;
      data_reg = t.write_data;
      left = t.read_length;
      restart_pending = 1'b0;
      ph = PH_ST0;
    end
    case (ph)
      PH_ST0: begin
        scl_d = 1'b1;
        sda_d = 1'b1;
        if (!t.sda_in) begin
          o.done_res = 1'b1;
          o.status = ST_BUS_BUSY;
          ph = PH_IDLE;
        end else begin
          ph = PH_ST1;
        end
      end
      PH_ST1: begin
        sda_d = 1'b0;
        if (t.sda_in) begin
          o.done_res = 1'b1;
          o.status = ST_BUS_BUSY;
          ph = PH_IDLE;
        end else begin
          ph = PH_ST2;
        end
      end
      PH_ST2: begin
        scl_d = 1'b0;
        if (restart_pending) load_byte(dev_addr + 8'd1, BY_DEV2);
        else load_byte(dev_addr, BY_DEV1);
      end
      PH_TXL: begin
        scl_d = 1'b0;
        ph = PH_TXD;
      end
      PH_TXD: begin
        sda_d = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        ph = PH_TXH;
      end
      PH_TXH: begin
        scl_d = 1'b1;
        bit_cnt = bit_cnt + 3'd1;
        ph = (bit_cnt == 3'd0) ? PH_AK0 : PH_TXL;
      end
      PH_AK0: begin
        scl_d = 1'b0;
        ph = PH_AK1;
      end
      PH_AK1: begin
        sda_d = 1'b1;
        ph = PH_AK2;
      end
      PH_AK2: begin
        scl_d = 1'b1;
        if ((stage == BY_DEV1 || stage == BY_DEV2) && t.sda_in) begin
          stopk = STOP_ABORT;
          ph = PH_SP0;
        end else if (stage == BY_DEV1) begin
          load_byte(addr_reg, BY_REG);
        end else if (stage == BY_REG) begin
          if (rd) begin
            stopk = STOP_RESTART;
            ph = PH_SP0;
          end else begin
            load_byte(data_reg, BY_DATA);
          end
        end else if (stage == BY_DATA || left == 8'd0) begin
          stopk = STOP_FINAL;
          ph = PH_SP0;
        end else begin
          bit_cnt = '0;
          shreg = '0;
          ph = PH_RXL;
        end
      end
      PH_RXL: begin
        scl_d = 1'b0;
        sda_d = 1'b1;
        ph = PH_RXH;
      end
      PH_RXH: begin
        scl_d = 1'b1;
        shreg = {shreg[6:0], t.sda_in};
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt == 3'd0) begin
          o.read_valid = 1'b1;
          o.read_data = shreg;
          o.read_last = (left == 8'd1);
          ph = PH_MA0;
        end else begin
          ph = PH_RXL;
        end
      end
      PH_MA0: begin
        scl_d = 1'b0;
        ph = PH_MA1;
      end
      PH_MA1: begin
        // ack low, or release for the final nack
        sda_d = (left == 8'd1);
        ph = PH_MA2;
      end
      PH_MA2: begin
        scl_d = 1'b1;
        ph = PH_MA3;
      end
      PH_MA3: begin
        scl_d = 1'b0;
        left = left - 8'd1;
        if (left == 8'd0) begin
          stopk = STOP_FINAL;
          ph = PH_SP0;
        end else begin
          bit_cnt = '0;
          shreg = '0;
          ph = PH_RXL;
        end
      end
      PH_SP0: begin
        scl_d = 1'b0;
        ph = PH_SP1;
      end
      PH_SP1: begin
        sda_d = 1'b0;
        ph = PH_SP2;
      end
      PH_SP2: begin
        scl_d = 1'b1;
        ph = PH_SP3;
      end
      PH_SP3: begin
        sda_d = 1'b1;
        if (stopk == STOP_RESTART) begin
          restart_pending = 1'b1;
          ph = PH_ST0;
        end else begin
          o.done_res = 1'b1;
          o.status = (stopk == STOP_ABORT) ? ST_ADDR_NACK : ST_OK;
          ph = PH_IDLE;
        end
      end
      default: ph = PH_IDLE;
    endcase
    o.scl_out = scl_d;
    o.sda_out = sda_d;
    o.busy_res = (ph != PH_IDLE);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < MAX_PRINTED)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    reset_sequencer();
  end

  always @(posedge clk) begin
    in_item_t  t;
    out_item_t want;
    out_item_t got;
    if (rst) begin
      reset_sequencer();
      tick_results_q.delete();
      ticks_checked = 0;
      bytes_read = 0;
      ends_ok = 0;
      ends_bus_busy = 0;
      ends_nack = 0;
    end else begin
      if (cfg.valid && cfg.ready) dev_addr = cfg.device_address;
      if (req.valid && req.ready) begin
        t.opcode = req.opcode;
        t.reg_address = req.reg_address;
        t.write_data = req.write_data;
        t.read_length = req.read_length;
        t.sda_in = req.sda_in;
        want = bus_tick(t);
        tick_results_q.push_back(want);
        if (want.read_valid) bytes_read++;
        if (want.done_res) begin
          if (want.status == ST_OK) ends_ok++;
          else if (want.status == ST_BUS_BUSY) ends_bus_busy++;
          else ends_nack++;
        end
      end
      if (rsp.valid && rsp.ready) begin
        got.scl_out = rsp.scl_out;
        got.sda_out = rsp.sda_out;
        got.busy_res = rsp.busy_res;
        got.done_res = rsp.done_res;
        got.status = rsp.status;
        got.read_data = rsp.read_data;
        got.read_valid = rsp.read_valid;
        got.read_last = rsp.read_last;
        if (tick_results_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          want = tick_results_q.pop_front();
          ticks_checked++;
          check_field("scl_out", got.scl_out, want.scl_out);
          check_field("sda_out", got.sda_out, want.sda_out);
          check_field("busy_res", got.busy_res, want.busy_res);
          check_field("done_res", got.done_res, want.done_res);
          check_field("status", got.status, want.status);
          check_field("read_data", got.read_data, want.read_data);
          check_field("read_valid", got.read_valid, want.read_valid);
          check_field("read_last", got.read_last, want.read_last);
        end
      end
    end
    pending = tick_results_q.size();
  end

endmodule

>>> tb/sccb_register_master_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for sccb_register_master. Every request transaction is
// one bus tick. Most bus operations are built tick by tick so that the data
// line answers exactly where the sequencer samples it (start checks, address
// acks, read bits); the rest is noise followed by a drain that always brings
// the sequencer back to idle. All checking lives in the checker instance.
module sccb_register_master_test;
  import sccb_pkg::*;

  // Opcode three has no meaning; the block treats it as a plain tick.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_TICKS = 600;
  localparam int PHASE_TICKS  = 400;
  // Enough all-high ticks to end anything a noise burst can start: the read
  // lengths in noise are kept at 7 or less, so at most about 150 ticks remain.
  localparam int DRAIN_TICKS  = 160;

  // Where the emulated device misbehaves during a bus operation.
  typedef enum int {
    FAULT_NONE,
    FAULT_START_LOW,    // data line low at the first start check
    FAULT_START_HIGH,   // data line stays high after the master pulls it low
    FAULT_DEV_NACK,     // no ack for the write address
    FAULT_RESTART_LOW,  // data line low at the repeated start of a read
    FAULT_DEV2_NACK     // no ack for the read address
  } fault_t;

  logic clk;
  logic rst;

  sccb_in_if  req_ch();
  sccb_out_if rsp_ch();
  sccb_cfg_if cfg_ch();

  int fail_count;
  int pending;
  int ticks_checked;
  int bytes_read;
  int ends_ok;
  int ends_bus_busy;
  int ends_nack;

  int cycle_count;
  int ticks_sent;
  int addr_settings;
  int tx_calm;     // sender ticks left in a no-gap stretch
  int rx_calm;     // receiver cycles left in a no-stall stretch
  int rx_stall;    // receiver cycles left in the current stall

  sccb_register_master uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  sccb_register_master_checker chk (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg           (cfg_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .ticks_checked (ticks_checked),
    .bytes_read    (bytes_read),
    .ends_ok       (ends_ok),
    .ends_bus_busy (ends_bus_busy),
    .ends_nack     (ends_nack)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs on a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAIL sccb_register_master");
      $finish;
    end
  end

  // Result side backpressure: mostly short stalls, a few long ones, and
  // stretches with ready held high.
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      rsp_ch.ready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm <= rx_calm - 1;
      rsp_ch.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:1]:   begin rx_calm <= $urandom_range(30, 150); rsp_ch.ready <= 1'b1; end
        [2:24]:  begin rx_stall <= $urandom_range(0, 2); rsp_ch.ready <= 1'b0; end
        [25:27]: begin rx_stall <= $urandom_range(8, 40); rsp_ch.ready <= 1'b0; end
        default: rsp_ch.ready <= 1'b1;
      endcase
    end
  end

  // Idle cycles before the next request transaction.
  function automatic int sender_gap();
    int r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      tx_calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 62) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // A tick sent while the sequencer is busy. Now and then it carries a begin
  // opcode, which must be ignored, and all operand fields are random.
  function automatic in_item_t busy_tick(input logic sda);
    in_item_t it;
    case ($urandom_range(0, 19))
      0:       it.opcode = OP_WRITE;
      1:       it.opcode = OP_READ;
      2:       it.opcode = OP_UNUSED;
      default: it.opcode = OP_TICK;
    endcase
    it.reg_address = 8'($urandom_range(0, 255));
    it.write_data = 8'($urandom_range(0, 255));
    it.read_length = 8'($urandom_range(0, 255));
    it.sda_in = sda;
    return it;
  endfunction

  // One request transaction, with a random gap in front of it.
  task automatic send(input in_item_t it);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= it.opcode;
    req_ch.reg_address <= it.reg_address;
    req_ch.write_data <= it.write_data;
    req_ch.read_length <= it.read_length;
    req_ch.sda_in <= it.sda_in;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Eight bits out (three ticks each), then the ack slot; only the last ack
  // tick samples the data line.
  task automatic send_byte(input logic ack_level);
    repeat (26) send(busy_tick(coin()));
    send(busy_tick(ack_level));
  endtask

  task automatic send_stop();
    repeat (4) send(busy_tick(coin()));
  endtask

  // Ticks while idle: never a begin opcode, so nothing starts.
  task automatic idle_ticks(input int n);
    in_item_t it;
    repeat (n) begin
      it = busy_tick(coin());
      it.opcode = coin() ? OP_UNUSED : OP_TICK;
      send(it);
    end
  endtask

  // A complete register write or read, tick for tick, with the device
  // answering as the fault asks. Ends on the tick that reports done.
  task automatic run_access(input logic is_rd, input logic [7:0] ra, input logic [7:0] wd,
                            input logic [7:0] len, input fault_t fault);
    in_item_t it;
    it = busy_tick(fault != FAULT_START_LOW);
    it.opcode = is_rd ? OP_READ : OP_WRITE;
    it.reg_address = ra;
    it.write_data = wd;
    it.read_length = len;
    send(it);
    if (fault == FAULT_START_LOW) return;
    send(busy_tick(fault == FAULT_START_HIGH));
    if (fault == FAULT_START_HIGH) return;
    send(busy_tick(coin()));
    send_byte(fault == FAULT_DEV_NACK);
    if (fault == FAULT_DEV_NACK) begin
      send_stop();
      return;
    end
    // register address; its ack level does not matter
    send_byte(coin());
    if (!is_rd) begin
      send_byte(coin());
      send_stop();
      return;
    end
    // stop, then the repeated start with the read address
    send_stop();
    send(busy_tick(fault != FAULT_RESTART_LOW));
    if (fault == FAULT_RESTART_LOW) return;
    send(busy_tick(1'b0));
    send(busy_tick(coin()));
    send_byte(fault == FAULT_DEV2_NACK);
    if (fault == FAULT_DEV2_NACK) begin
      send_stop();
      return;
    end
    repeat (len) begin
      repeat (16) send(busy_tick(coin()));
      repeat (4) send(busy_tick(coin()));
    end
    send_stop();
  endtask

  // Random operands and mostly small read lengths; a quarter of the
  // operations carry a fault.
  task automatic random_access();
    logic   is_rd;
    logic [7:0] len;
    fault_t fault;
    int     r;
    is_rd = coin();
    r = $urandom_range(0, 99);
    if (r < 70) len = 8'($urandom_range(0, 3));
    else if (r < 95) len = 8'($urandom_range(4, 12));
    else len = 8'($urandom_range(13, 40));
    fault = FAULT_NONE;
    if ($urandom_range(0, 3) == 0) fault = fault_t'($urandom_range(1, 5));
    run_access(is_rd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len, fault);
  endtask

  // A begin followed by ticks with random data line levels and opcodes, then
  // an all-high drain that ends whatever the burst left running.
  task automatic noisy_access();
    in_item_t it;
    int       n;
    n = $urandom_range(10, 80);
    it = busy_tick(coin());
    it.opcode = coin() ? OP_READ : OP_WRITE;
    it.read_length = 8'($urandom_range(0, 7));
    send(it);
    repeat (n) begin
      it = busy_tick(coin());
      it.read_length = 8'($urandom_range(0, 7));
      send(it);
    end
    repeat (DRAIN_TICKS) begin
      it = busy_tick(1'b1);
      it.opcode = OP_TICK;
      send(it);
    end
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Config writes only while idle and drained; the short pause covers the
  // two-stage path between request and result.
  task automatic set_device_address(input logic [7:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.device_address <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    addr_settings++;
  endtask

  initial begin
    int start_ticks;
    cycle_count = 0;
    ticks_sent = 0;
    addr_settings = 0;
    tx_calm = 0;
    rx_calm = 0;
    rx_stall = 0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_TICK;
    req_ch.reg_address = '0;
    req_ch.write_data = '0;
    req_ch.read_length = '0;
    req_ch.sda_in = 1'b1;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.device_address = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset device address: operand extremes, both
    // operations, every start / ack failure, an empty read, a longer read,
    // and the meaningless opcode while idle.
    idle_ticks(3);
    run_access(1'b0, 8'h00, 8'h00, 8'd0, FAULT_NONE);
    run_access(1'b0, 8'hFF, 8'hFF, 8'hFF, FAULT_NONE);
    run_access(1'b1, 8'h55, 8'hAA, 8'd1, FAULT_NONE);
    run_access(1'b1, 8'hA5, 8'h00, 8'd0, FAULT_NONE);
    run_access(1'b1, 8'h3C, 8'h00, 8'd2, FAULT_NONE);
    run_access(1'b0, 8'h12, 8'h34, 8'd0, FAULT_START_LOW);
    idle_ticks(2);
    run_access(1'b1, 8'h12, 8'h34, 8'd3, FAULT_START_HIGH);
    run_access(1'b0, 8'h80, 8'h01, 8'd0, FAULT_DEV_NACK);
    run_access(1'b1, 8'h7F, 8'h00, 8'd2, FAULT_DEV_NACK);
    run_access(1'b1, 8'h01, 8'h00, 8'd2, FAULT_RESTART_LOW);
    run_access(1'b1, 8'hFE, 8'h00, 8'd2, FAULT_DEV2_NACK);
    run_access(1'b1, 8'hC3, 8'h00, 8'd12, FAULT_NONE);

    set_device_address(8'h00);
    run_access(1'b0, 8'h10, 8'h5A, 8'd0, FAULT_NONE);
    run_access(1'b1, 8'h20, 8'h00, 8'd2, FAULT_NONE);
    set_device_address(8'hFE);
    run_access(1'b0, 8'h30, 8'hC3, 8'd0, FAULT_NONE);
    run_access(1'b1, 8'h40, 8'h00, 8'd1, FAULT_NONE);

    // Random part in phases, each with its own device address.
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < RANDOM_TICKS) begin
      set_device_address(8'($urandom_range(0, 254)));
      while (ticks_sent - start_ticks < RANDOM_TICKS &&
             (ticks_sent - start_ticks) % PHASE_TICKS < PHASE_TICKS - 40) begin
        case ($urandom_range(0, 99)) inside
          [0:79]:  random_access();
          [80:89]: noisy_access();
          [90:97]: idle_ticks($urandom_range(1, 6));
          default: wait_drained();
        endcase
        idle_ticks($urandom_range(0, 3));
      end
      idle_ticks(40);
    end

    wait_drained();
    repeat (20) @(negedge clk);

    $display("Checked %0d ticks over %0d device address settings; %0d bytes read.",
             ticks_checked, addr_settings + 1, bytes_read);
    $display("Operations ended: %0d ok, %0d bus not free, %0d address not acknowledged.",
             ends_ok, ends_bus_busy, ends_nack);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS sccb_register_master");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("FAIL sccb_register_master");
    end
    $finish;
  end

endmodule
